@@ rtl/lod_pkg.sv @@
package lod_pkg;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_DEADLOCK       = 3'd1;
  localparam logic [2:0] ST_MULTI_UNLOCK   = 3'd2;
  localparam logic [2:0] ST_INVALID_UNLOCK = 3'd3;
  localparam logic [2:0] ST_FULL           = 3'd4;
  localparam logic [2:0] ST_HALTED         = 3'd5;

  localparam logic ACT_ACQUIRE = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_EDGE,
    S_ROOT,
    S_ROWW,
    S_SCAN,
    S_POPW,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       latch_in;
    logic       push;
    logic       pop;
    logic       set_halt;
    logic       row_rd_top;
    logic       edge_wr;
    logic       search_init;
    logic       root_inc;
    logic       root_start;
    logic       row_cap;
    logic       t_inc;
    logic       frame_done;
    logic       pop_rd;
    logic       pop_load;
    logic       push_child;
    logic       res_set;
    logic       res_cyc;
    logic [2:0] res_code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic halted;
    logic level_zero;
    logic level_full;
    logic top_eq_id;
    logic edge_present;
    logic root_end;
    logic root_seen;
    logic t_end;
    logic t_bit;
    logic t_seen;
    logic t_done;
    logic sp_zero;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/lod_ctrl.sv @@
module lod_ctrl
  import lod_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.halted && stat.action == ACT_ACQUIRE && !stat.level_full &&
            !stat.level_zero && !stat.top_eq_id) begin
          state_next = S_EDGE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_EDGE: begin
        state_next = stat.edge_present ? S_OUT : S_ROOT;
      end
      S_ROOT: begin
        if (stat.root_end) state_next = S_OUT;
        else if (!stat.root_seen) state_next = S_ROWW;
      end
      S_ROWW: state_next = S_SCAN;
      S_SCAN: begin
        if (stat.t_end) begin
          state_next = stat.sp_zero ? S_ROOT : S_POPW;
        end else if (stat.t_bit) begin
          if (!stat.t_seen) state_next = S_ROWW;
          else if (!stat.t_done) state_next = S_OUT;
        end
      end
      S_POPW: state_next = S_ROWW;
      S_OUT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_code = ST_OK;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_EVAL: begin
        cmd.res_set = 1'b1;
        if (stat.halted) begin
          cmd.res_code = ST_HALTED;
        end else if (stat.action == ACT_ACQUIRE) begin
          if (stat.level_full) begin
            cmd.res_code = ST_FULL;
            cmd.set_halt = 1'b1;
          end else if (stat.level_zero || stat.top_eq_id) begin
            cmd.push = 1'b1;
          end else begin
            cmd.res_set = 1'b0;
            cmd.row_rd_top = 1'b1;
          end
        end else if (stat.level_zero) begin
          cmd.res_code = ST_MULTI_UNLOCK;
          cmd.set_halt = 1'b1;
        end else if (!stat.top_eq_id) begin
          cmd.res_code = ST_INVALID_UNLOCK;
          cmd.set_halt = 1'b1;
        end else begin
          cmd.pop = 1'b1;
        end
      end
      S_EDGE: begin
        if (stat.edge_present) begin
          cmd.push = 1'b1;
          cmd.res_set = 1'b1;
        end else begin
          cmd.edge_wr = 1'b1;
          cmd.search_init = 1'b1;
        end
      end
      S_ROOT: begin
        if (stat.root_end) begin
          cmd.push = 1'b1;
          cmd.res_set = 1'b1;
        end else if (stat.root_seen) begin
          cmd.root_inc = 1'b1;
        end else begin
          cmd.root_start = 1'b1;
        end
      end
      S_ROWW: cmd.row_cap = 1'b1;
      S_SCAN: begin
        if (stat.t_end) begin
          cmd.frame_done = 1'b1;
          if (stat.sp_zero) cmd.root_inc = 1'b1;
          else cmd.pop_rd = 1'b1;
        end else if (!stat.t_bit) begin
          cmd.t_inc = 1'b1;
        end else if (!stat.t_seen) begin
          cmd.push_child = 1'b1;
        end else if (!stat.t_done) begin
          // back edge to a node still on the search path
          cmd.res_set = 1'b1;
          cmd.res_cyc = 1'b1;
          cmd.res_code = ST_DEADLOCK;
          cmd.set_halt = 1'b1;
        end else begin
          cmd.t_inc = 1'b1;
        end
      end
      S_POPW: cmd.pop_load = 1'b1;
      S_OUT: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/lod_dp.sv @@
module lod_dp
  import lod_pkg::*;
#(
  parameter int NUM_LOCKS   = 32,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_action,
  input  logic [4:0]  in_lock_id,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_cycle_from,
  output logic [4:0]  out_cycle_to,
  output logic [4:0]  out_held_count
);

  localparam int IW = $clog2(NUM_LOCKS);
  localparam int TW = IW + 1;
  localparam int HW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int EW = IW + TW;

  logic [IW-1:0]        id;
  logic                 action;
  logic                 halted;
  logic [LW-1:0]        held_level;
  logic [LW-1:0]        level_m1;
  logic [IW-1:0]        held_mem [STACK_DEPTH];
  logic [IW-1:0]        held_top;

  logic [NUM_LOCKS-1:0] edge_mem [NUM_LOCKS];
  logic [NUM_LOCKS-1:0] row_valid;
  logic [NUM_LOCKS-1:0] mrd;
  logic                 mrv;
  logic [NUM_LOCKS-1:0] row_data;
  logic [NUM_LOCKS-1:0] row;
  logic [IW-1:0]        maddr;

  logic [EW-1:0]        stack_mem [NUM_LOCKS];
  logic [EW-1:0]        srd;
  logic [IW-1:0]        sp;
  logic [NUM_LOCKS-1:0] seen;
  logic [NUM_LOCKS-1:0] done;
  logic [TW-1:0]        root;
  logic [IW-1:0]        here;
  logic [TW-1:0]        t;

  logic [2:0]           res_status;
  logic [IW-1:0]        res_from;
  logic [IW-1:0]        res_to;

  // fold lock numbers at or above NUM_LOCKS back into range
  function automatic logic [IW-1:0] wrap_id(input logic [4:0] raw);
    logic [IW-1:0] folded;
    folded = '0;
    for (int k = 0; k < 32; k++) begin
      if (raw == 5'(k)) folded = IW'(k % NUM_LOCKS);
    end
    return folded;
  endfunction

  assign level_m1 = held_level - LW'(1);
  assign row_data = mrv ? mrd : '0;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action <= in_action;
      id     <= wrap_id(in_lock_id);
    end
  end

  // held lock stack: read the top every cycle
  always_ff @(posedge clk) begin
    if (cmd.push) held_mem[held_level[HW-1:0]] <= id;
    held_top <= held_mem[level_m1[HW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_level <= '0;
      halted     <= 1'b0;
    end else begin
      if (cmd.push) held_level <= held_level + LW'(1);
      else if (cmd.pop) held_level <= level_m1;
      if (cmd.set_halt) halted <= 1'b1;
    end
  end

  always_comb begin
    maddr = held_top;
    if (cmd.root_start) maddr = root[IW-1:0];
    else if (cmd.push_child) maddr = t[IW-1:0];
    else if (cmd.pop_load) maddr = srd[EW-1:TW];
  end

  // lock-order matrix, one row per source lock
  always_ff @(posedge clk) begin
    if (cmd.edge_wr) edge_mem[held_top] <= row_data | (NUM_LOCKS'(1) << id);
    mrd <= edge_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      mrv       <= 1'b0;
    end else begin
      if (cmd.edge_wr) row_valid[held_top] <= 1'b1;
      mrv <= row_valid[maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_child) stack_mem[sp] <= {here, t + TW'(1)};
    if (cmd.pop_rd) srd <= stack_mem[sp - IW'(1)];
  end

  always_ff @(posedge clk) begin
    if (cmd.row_cap) row <= row_data;
    if (cmd.search_init) begin
      seen <= '0;
      done <= '0;
      root <= '0;
    end else begin
      if (cmd.root_inc) root <= root + TW'(1);
      if (cmd.root_start) begin
        seen[root[IW-1:0]] <= 1'b1;
        here <= root[IW-1:0];
        t    <= '0;
        sp   <= '0;
      end
      if (cmd.t_inc) t <= t + TW'(1);
      if (cmd.frame_done) done[here] <= 1'b1;
      if (cmd.pop_rd) sp <= sp - IW'(1);
      if (cmd.push_child) begin
        seen[t[IW-1:0]] <= 1'b1;
        sp   <= sp + IW'(1);
        here <= t[IW-1:0];
        t    <= '0;
      end
      if (cmd.pop_load) begin
        here <= srd[EW-1:TW];
        t    <= srd[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_from   <= cmd.res_cyc ? here : '0;
      res_to     <= cmd.res_cyc ? t[IW-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_status     <= res_status;
      out_cycle_from <= 5'(res_from);
      out_cycle_to   <= 5'(res_to);
      out_held_count <= 5'(held_level);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.action       = action;
    stat.halted       = halted;
    stat.level_zero   = (held_level == '0);
    stat.level_full   = (held_level == LW'(STACK_DEPTH));
    stat.top_eq_id    = (held_top == id);
    stat.edge_present = row_data[id];
    stat.root_end     = (root == TW'(NUM_LOCKS));
    stat.root_seen    = seen[root[IW-1:0]];
    stat.t_end        = (t == TW'(NUM_LOCKS));
    stat.t_bit        = row[t[IW-1:0]];
    stat.t_seen       = seen[t[IW-1:0]];
    stat.t_done       = done[t[IW-1:0]];
    stat.sp_zero      = (sp == '0);
    stat.out_free     = !out_valid || out_ready;
  end

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    held_level <= LW'(STACK_DEPTH))
    else $error("held level above stack depth");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt cleared without reset");
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop in one cycle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("result overwritten while waiting");
`endif

endmodule

@@ rtl/lock_order_cycle_detector_top.sv @@
// Halted items, releases, a full stack and acquires on an empty stack or of the top lock
//   are settled in the evaluate state; an edge already recorded adds the edge check.
// A new edge runs a depth-first search of the lock-order matrix, one matrix
//   bit per cycle while scanning a row, with a row fetch before each row.
// One request in flight: a new request is taken only after the last result is loaded out.
// Reset (synchronous) empties the held-lock stack, clears graph rows and the halt flag.
module lock_order_cycle_detector_top
  import lod_pkg::*;
#(
  parameter int NUM_LOCKS   = 32,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] lock_id
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [2:0] status, [7:3] cycle_from, [12:8] cycle_to,
                                 // [17:13] held_count
);

  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] status;
  logic [4:0] cycle_from;
  logic [4:0] cycle_to;
  logic [4:0] held_count;

  lod_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lod_dp #(
    .NUM_LOCKS   (NUM_LOCKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_action      (s_tuser[0]),
    .in_lock_id     (s_tdata[4:0]),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_status     (status),
    .out_cycle_from (cycle_from),
    .out_cycle_to   (cycle_to),
    .out_held_count (held_count)
  );

  assign m_tdata = {6'b0, held_count, cycle_to, cycle_from, status};

endmodule
